@@ sv/erm_pkg.sv @@
// ----------------------------------------------------------------------------
// erm_pkg: shared types and constants of the encoder reply speed meter
// Field widths, Modbus reply constants and the reply record that the
// byte receiver passes to the speed sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package erm_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_STATION = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNT   = 1'd1;

  // input item kinds (carried on tuser)
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // stream widths
  localparam int IN_DATA_W  = 40;  // data_byte, timestamp
  localparam int OUT_DATA_W = 96;  // six 16-bit fields

  // reply framing
  localparam int          HDR_LEN     = 5;
  localparam int          HDR_IDX_W   = $clog2(HDR_LEN);
  localparam logic [8:0]  FRAME_EXTRA = 9'd5;
  localparam logic [7:0]  FUNC_READ   = 8'h03;
  localparam logic [7:0]  PTR_MAX     = 8'd255;
  localparam logic [7:0]  STATION_RST = 8'd2;
  localparam logic [6:0]  COUNT_RST   = 7'd1;

  // encoder wrap handling
  localparam int          ENCODER_RANGE = 4096;
  localparam logic [15:0] RANGE_W   = 16'(ENCODER_RANGE);
  localparam logic [15:0] QUARTER_W = 16'(ENCODER_RANGE / 4);
  localparam logic [15:0] THREE_Q_W = 16'(ENCODER_RANGE - ENCODER_RANGE / 4);

  // speed scaling and the serial divider
  localparam logic signed [10:0] SPEED_SCALE = 11'sd1000;
  localparam int PROD_W = 26;               // |delta*1000| < 2**25
  localparam int DIV_W  = PROD_W - 1;       // dividend magnitude bits
  localparam int DEN_W  = 16;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam logic [DIV_W-1:0] QUO_POS_MAX = DIV_W'(32767);
  localparam logic [DIV_W-1:0] QUO_NEG_MAX = DIV_W'(32768);
  localparam logic [15:0] SPD_POS_SAT = 16'h7FFF;
  localparam logic [15:0] SPD_NEG_SAT = 16'h8000;

  typedef struct packed {
    logic               valid;
    logic [15:0]        position;
    logic [15:0]        elapsed_ticks;
    logic signed [15:0] angle_delta;
    logic [15:0]        error_count;
    logic [15:0]        good_count;
  } erm_reply_t;

endpackage

`default_nettype wire

@@ sv/erm_div.sv @@
// ----------------------------------------------------------------------------
// erm_div: serial unsigned divider
// Restoring division, one quotient bit per cycle; done pulses in the cycle
// after the last step and the quotient then holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module erm_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [erm_pkg::DIV_W-1:0]  dividend,
  input  wire logic [erm_pkg::DEN_W-1:0]  divisor,
  output logic                            done,
  output logic [erm_pkg::DIV_W-1:0]       quotient
);
  import erm_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ sv/erm_rx.sv @@
// ----------------------------------------------------------------------------
// erm_rx: reply byte receiver
// Tracks the frame position, keeps the header bytes, checks station,
// function and byte count, and on a good reply registers the reply record.
// ----------------------------------------------------------------------------
`default_nettype none

module erm_rx (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [erm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [erm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            accept,
  input  wire logic                            operation,
  input  wire logic [7:0]                      data_byte,
  input  wire logic [31:0]                     timestamp,
  output erm_pkg::erm_reply_t                  reply
);
  import erm_pkg::*;

  logic [7:0]  station_r;
  logic [6:0]  regcnt_r;
  logic [7:0]  ptr_r, ptr_nxt;
  logic [7:0]  hdr_r [HDR_LEN];
  logic        pend_r, pend_nxt;
  logic        disc_r, disc_nxt;
  logic [15:0] prev_pos_r, prev_pos_nxt;
  logic [31:0] prev_tick_r, prev_tick_nxt;
  logic [15:0] err_cnt_r, err_cnt_nxt;
  logic [15:0] good_cnt_r, good_cnt_nxt;
  erm_reply_t  rep_r, rep_nxt;

  logic [8:0]  frame_len;
  logic [8:0]  ptr_inc;
  logic        hdr_wr;
  logic        hdr_ok;
  logic [15:0] pos;
  logic [31:0] tick_diff;
  logic        wrap_up, wrap_dn;
  logic [15:0] delta;

  assign frame_len = {1'b0, regcnt_r, 1'b0} + FRAME_EXTRA;
  assign ptr_inc   = {1'b0, ptr_r} + 9'd1;
  assign hdr_wr    = accept && (operation == OP_BYTE) && !disc_r &&
                     (ptr_r < 8'(HDR_LEN));
  assign hdr_ok    = (hdr_r[0] == station_r) && (hdr_r[1] == FUNC_READ) &&
                     (hdr_r[2] == {regcnt_r, 1'b0});

  // low position byte is the current byte for the shortest frame
  assign pos       = {hdr_r[3], (ptr_r == 8'd4) ? data_byte : hdr_r[4]};
  assign tick_diff = timestamp - prev_tick_r;
  assign wrap_up   = (pos < QUARTER_W) && (prev_pos_r > THREE_Q_W);
  assign wrap_dn   = (pos > THREE_Q_W) && (prev_pos_r < QUARTER_W);
  assign delta     = pos - prev_pos_r + (wrap_up ? RANGE_W : 16'd0)
                     - (wrap_dn ? RANGE_W : 16'd0);

  always_comb begin
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    disc_nxt      = disc_r;
    prev_pos_nxt  = prev_pos_r;
    prev_tick_nxt = prev_tick_r;
    err_cnt_nxt   = err_cnt_r;
    good_cnt_nxt  = good_cnt_r;
    rep_nxt       = rep_r;
    rep_nxt.valid = 1'b0;
    if (accept) begin
      if (operation == OP_POLL) begin
        if (pend_r) err_cnt_nxt = err_cnt_r + 16'd1;
        ptr_nxt  = '0;
        pend_nxt = 1'b1;
        disc_nxt = 1'b0;
      end else if (!disc_r && (ptr_r != PTR_MAX)) begin
        ptr_nxt = ptr_inc[7:0];
        if (ptr_inc == frame_len) begin
          if (!hdr_ok) begin
            disc_nxt = 1'b1;
          end else begin
            rep_nxt.valid         = 1'b1;
            rep_nxt.position      = pos;
            rep_nxt.elapsed_ticks = tick_diff[15:0];
            rep_nxt.angle_delta   = delta;
            rep_nxt.error_count   = err_cnt_r;
            rep_nxt.good_count    = good_cnt_r + 16'd1;
            prev_pos_nxt          = pos;
            prev_tick_nxt         = timestamp;
            good_cnt_nxt          = good_cnt_r + 16'd1;
            pend_nxt              = 1'b0;
            ptr_nxt               = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r   <= STATION_RST;
      regcnt_r    <= COUNT_RST;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      disc_r      <= 1'b0;
      prev_pos_r  <= '0;
      prev_tick_r <= '0;
      err_cnt_r   <= '0;
      good_cnt_r  <= '0;
      rep_r.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_STATION: station_r <= cfg_wdata;
          REG_COUNT:   regcnt_r  <= cfg_wdata[6:0];
          default:     ;
        endcase
      end
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      disc_r      <= disc_nxt;
      prev_pos_r  <= prev_pos_nxt;
      prev_tick_r <= prev_tick_nxt;
      err_cnt_r   <= err_cnt_nxt;
      good_cnt_r  <= good_cnt_nxt;
      rep_r.valid <= rep_nxt.valid;
    end
    rep_r.position      <= rep_nxt.position;
    rep_r.elapsed_ticks <= rep_nxt.elapsed_ticks;
    rep_r.angle_delta   <= rep_nxt.angle_delta;
    rep_r.error_count   <= rep_nxt.error_count;
    rep_r.good_count    <= rep_nxt.good_count;
    if (hdr_wr) hdr_r[ptr_r[HDR_IDX_W-1:0]] <= data_byte;
  end

  assign reply = rep_r;

endmodule

`default_nettype wire

@@ sv/encoder_reply_speed_meter_unit.sv @@
// ----------------------------------------------------------------------------
// encoder_reply_speed_meter_unit: Modbus encoder reply speed meter
// Parses encoder read replies and reports position, delta and speed.
// ----------------------------------------------------------------------------
// Poll items and bytes that do not end a good reply do not stall the input.
// The byte that ends a good reply drops ready until the result is loaded;
// the result passes frame check, multiply, divider load, the divider steps,
// divider done and output load before it is offered.
// Zero elapsed ticks skip the divider; a held result adds its stall.
// rst_n is synchronous: counters, frame state, configuration and valid flags go to reset.
`default_nettype none

module encoder_reply_speed_meter_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [erm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [erm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [7:0] data_byte, [39:8] timestamp
  input  wire logic [erm_pkg::IN_DATA_W-1:0]       in_tdata,
  // [0] operation
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [15:0] position, [31:16] elapsed_ticks, [47:32] angle_delta,
  // [63:48] speed, [79:64] error_count, [95:80] good_count
  output logic [erm_pkg::OUT_DATA_W-1:0]           out_tdata
);
  import erm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  erm_reply_t               rep;
  logic                     in_acc;
  logic signed [PROD_W:0]   prod_full;
  logic signed [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0]        prod_neg;
  logic [DIV_W-1:0]         dividend;
  logic                     div_start;
  logic                     div_done;
  logic [DIV_W-1:0]         quotient;
  logic [15:0]              quo_neg;
  logic [15:0]              speed_sat;
  logic [15:0]              last_speed_r;
  logic                     out_load;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;

  assign in_tready = (state_r == S_IDLE) && !rep.valid;
  assign in_acc    = in_tvalid && in_tready;

  erm_rx u_rx (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (in_acc),
    .operation (in_tuser),
    .data_byte (in_tdata[7:0]),
    .timestamp (in_tdata[39:8]),
    .reply     (rep)
  );

  assign prod_full = rep.angle_delta * SPEED_SCALE;
  assign prod_neg  = -prod_r;
  assign dividend  = prod_r[PROD_W-1] ? prod_neg[DIV_W-1:0] : prod_r[DIV_W-1:0];

  erm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (rep.elapsed_ticks),
    .done     (div_done),
    .quotient (quotient)
  );

  // truncated quotient, sign restored and clamped to 16 bits
  assign quo_neg = -quotient[15:0];
  always_comb begin
    if (prod_r[PROD_W-1]) begin
      speed_sat = (quotient > QUO_NEG_MAX) ? SPD_NEG_SAT : quo_neg;
    end else begin
      speed_sat = (quotient > QUO_POS_MAX) ? SPD_POS_SAT : quotient[15:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (rep.valid) state_nxt = (rep.elapsed_ticks == '0) ? S_OUT : S_MUL;
      end
      S_MUL:   state_nxt = S_START;
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_speed_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (div_done) last_speed_r <= speed_sat;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (state_r == S_MUL) prod_r <= prod_full[PROD_W-1:0];
    if (out_load) begin
      out_data_r <= {rep.good_count, rep.error_count, last_speed_r,
                     rep.angle_delta, rep.elapsed_ticks, rep.position};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_rep_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    rep.valid |-> !in_tready)
    else $error("input taken while a reply is being started");

  a_rep_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
    rep.valid |=> (state_r == S_MUL) || (state_r == S_OUT))
    else $error("good reply did not start the speed sequence");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid && (state_r == S_IDLE))
    else $error("result load did not raise the output");

  a_no_rep_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !rep.valid)
    else $error("reply arrived while the sequencer was busy");

endmodule

`default_nettype wire
